// ----- sv/vpa_pkg.sv -----
// Shared types and constants for the variable partition allocator.
package vpa_pkg;
   localparam int UsedSlotsDefault = 16;
   localparam int FreeSlotsDefault = 17;
   localparam int AddrBitsDefault  = 16;
   localparam logic [15:0] ResetTotal = 16'd1024;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_FIT   = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic [0:0] CSR_FIT_POLICY = 1'b0;
   localparam logic [0:0] CSR_TOTAL_SIZE = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_USCAN, S_FSCAN, S_ALLOC, S_INSPOS, S_INSERT,
      S_SHIFT, S_RESP, S_INIT
   } vpa_state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;        // capture request, clear scan counters
      logic uscan;       // examine one used slot
      logic fscan;       // examine one free slot
      logic do_alloc;    // commit allocation
      logic ins_pos;     // search insert position
      logic do_insert;   // commit merge / open gap
      logic shift;       // one shift step
      logic resp;        // raise response
      logic init;        // rebuild tables
   } vpa_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic is_free;     // request is a free
      logic uscan_done;
      logic slot_found;
      logic fscan_done;
      logic pick_found;
      logic pos_done;
      logic shift_done;
      logic need_shift;  // commit step needs a shift pass
   } vpa_stat_type;
endpackage

// ----- sv/vpa_if.sv -----
// Valid/ready channel interfaces for requests, responses and CSR writes.
interface vpa_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [15:0] req_size;
   logic [15:0] owner_id;
   modport source (output valid, mode, req_size, owner_id, input ready);
   modport sink   (input valid, mode, req_size, owner_id, output ready);
endinterface

interface vpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] region_start;
   logic [15:0] assigned_id;
   modport source (output valid, status, region_start, assigned_id, input ready);
   modport sink   (input valid, status, region_start, assigned_id, output ready);
endinterface

interface vpa_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/vpa_ctrl.sv -----
// Sequencing state machine for the allocator.
module vpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  init_req,
   input  logic                  rsp_taken,
   input  vpa_pkg::vpa_stat_type stat,
   output vpa_pkg::vpa_cmd_type  cmd,
   output logic                  idle
);
   import vpa_pkg::*;

   vpa_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (init_req)   state_in = S_INIT;
            else if (start) state_in = S_USCAN;
         end
         S_INIT:  state_in = S_IDLE;
         S_USCAN: begin
            if (stat.uscan_done) begin
               if (!stat.slot_found)  state_in = S_RESP;
               else if (stat.is_free) state_in = S_INSPOS;
               else                   state_in = S_FSCAN;
            end
         end
         S_FSCAN: begin
            if (stat.fscan_done) state_in = stat.pick_found ? S_ALLOC : S_RESP;
         end
         S_ALLOC:  state_in = stat.need_shift ? S_SHIFT : S_RESP;
         S_INSPOS: if (stat.pos_done) state_in = S_INSERT;
         S_INSERT: state_in = stat.need_shift ? S_SHIFT : S_RESP;
         S_SHIFT:  if (stat.shift_done) state_in = S_RESP;
         S_RESP:   if (rsp_taken) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      idle = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            idle = !init_req;
            cmd.load = start && !init_req;
         end
         S_INIT:   cmd.init = 1'b1;
         S_USCAN:  cmd.uscan = 1'b1;
         S_FSCAN:  cmd.fscan = 1'b1;
         S_ALLOC:  cmd.do_alloc = 1'b1;
         S_INSPOS: cmd.ins_pos = 1'b1;
         S_INSERT: cmd.do_insert = 1'b1;
         S_SHIFT:  cmd.shift = 1'b1;
         S_RESP:   cmd.resp = 1'b1;
         default:  cmd = '0;
      endcase
   end
endmodule

// ----- sv/vpa_dp.sv -----
// Table storage and scan datapath for the allocator.
module vpa_dp #(
   parameter int USED_SLOTS = vpa_pkg::UsedSlotsDefault,
   parameter int FREE_SLOTS = vpa_pkg::FreeSlotsDefault,
   parameter int ADDR_BITS  = vpa_pkg::AddrBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  vpa_pkg::vpa_cmd_type  cmd,
   output vpa_pkg::vpa_stat_type stat,
   input  logic                  in_mode,
   input  logic [15:0]           in_size,
   input  logic [15:0]           in_id,
   input  logic [1:0]            fit_policy,
   input  logic [15:0]           total_size,
   output logic [1:0]            out_status,
   output logic [15:0]           out_start,
   output logic [15:0]           out_id
);
   import vpa_pkg::*;

   localparam int UW = $clog2(USED_SLOTS + 1);
   localparam int UI = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;
   localparam int FW = $clog2(FREE_SLOTS + 1);
   localparam int FI = $clog2(FREE_SLOTS);
   localparam int AW = ADDR_BITS;

   logic [AW-1:0] fstart_ff [FREE_SLOTS];
   logic [AW-1:0] flen_ff   [FREE_SLOTS];
   logic [FW-1:0] fcount_ff;
   logic [USED_SLOTS-1:0] uvalid_ff;
   logic [15:0]   uid_ff    [USED_SLOTS];
   logic [AW-1:0] ustart_ff [USED_SLOTS];
   logic [AW-1:0] ulen_ff   [USED_SLOTS];
   logic [15:0]   idc_ff;

   logic          mode_ff;
   logic [AW-1:0] size_ff;
   logic [15:0]   oid_ff;
   logic [UW-1:0] ui_ff;
   logic          sfound_ff;
   logic [UI-1:0] slot_ff;
   logic [FW-1:0] fi_ff;
   logic          pfound_ff;
   logic [FI-1:0] pick_ff;
   logic [AW-1:0] plen_ff;
   logic [AW-1:0] rs_ff;      // region start
   logic [AW-1:0] rl_ff;      // region length (for free)
   logic [1:0]    status_ff;
   // shift pass: sh_dir 0 closes gap at sh_i (left), 1 opens gap (right)
   logic          sh_dir_ff;
   logic [FW-1:0] sh_i_ff;
   logic [FW-1:0] sh_end_ff;
   logic [AW-1:0] ns_ff, nl_ff;  // entry written into opened gap

   logic [UI-1:0] ui_idx;
   logic [FI-1:0] fi_idx, fi_prev, sh_idx;
   logic [AW-1:0] cur_len;
   logic          better;

   assign ui_idx  = ui_ff[UI-1:0];
   assign fi_idx  = fi_ff[FI-1:0];
   assign fi_prev = fi_idx - 1'b1;
   assign sh_idx  = sh_i_ff[FI-1:0];
   assign cur_len = flen_ff[fi_idx];

   always_comb begin
      unique case (fit_policy)
         FIT_BEST:  better = cur_len < plen_ff;
         FIT_WORST: better = cur_len > plen_ff;
         default:   better = 1'b0;
      endcase
   end

   // insert position logic at fi (pos)
   logic mp, mn;
   assign mp = (fi_ff != '0) &&
               ((fstart_ff[fi_prev] + flen_ff[fi_prev]) == rs_ff);
   assign mn = (fi_ff < fcount_ff) && ((rs_ff + rl_ff) == fstart_ff[fi_idx]);

   always_comb begin
      stat.is_free    = mode_ff;
      stat.uscan_done = (ui_ff == UW'(USED_SLOTS - 1)) ||
                        (mode_ff ? (uvalid_ff[ui_idx] && uid_ff[ui_idx] == oid_ff)
                                 : !uvalid_ff[ui_idx]);
      stat.slot_found = sfound_ff || (mode_ff
                        ? (uvalid_ff[ui_idx] && uid_ff[ui_idx] == oid_ff)
                        : !uvalid_ff[ui_idx]);
      stat.fscan_done = (fi_ff >= fcount_ff);
      stat.pick_found = pfound_ff;
      stat.pos_done   = (fi_ff >= fcount_ff) || (fstart_ff[fi_idx] >= rs_ff);
      stat.shift_done = sh_dir_ff ? (sh_i_ff <= sh_end_ff)
                                  : (sh_i_ff + 1'b1 >= sh_end_ff);
      if (cmd.do_alloc)
         stat.need_shift = !(plen_ff > size_ff);
      else
         stat.need_shift = (rl_ff != '0) &&
            ((mp && mn) || (!mp && !mn && fcount_ff < FW'(FREE_SLOTS)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idc_ff    <= '0;
         uvalid_ff <= '0;
         fcount_ff <= FW'(1);
         fstart_ff[0] <= '0;
         flen_ff[0]   <= AW'(ResetTotal);
      end else begin
         if (cmd.init) begin
            uvalid_ff <= '0;
            fstart_ff[0] <= '0;
            flen_ff[0]   <= AW'(total_size);
            fcount_ff <= (AW'(total_size) != '0) ? FW'(1) : '0;
         end
         if (cmd.load) begin
            mode_ff   <= in_mode;
            size_ff   <= AW'(in_size);
            ui_ff     <= '0;
            fi_ff     <= '0;
            sfound_ff <= 1'b0;
            pfound_ff <= 1'b0;
            rs_ff     <= '0;
            if (!in_mode) begin
               idc_ff <= idc_ff + 16'd1;
               oid_ff <= idc_ff + 16'd1;
            end else begin
               oid_ff <= in_id;
            end
         end
         if (cmd.uscan) begin
            if (stat.uscan_done) begin
               sfound_ff <= stat.slot_found;
               slot_ff   <= ui_idx;
               if (!stat.slot_found)
                  status_ff <= mode_ff ? ST_NOT_FOUND : ST_FULL;
               else if (mode_ff) begin
                  uvalid_ff[ui_idx] <= 1'b0;
                  rs_ff  <= ustart_ff[ui_idx];
                  rl_ff  <= ulen_ff[ui_idx];
                  status_ff <= ST_OK;
               end
            end else begin
               ui_ff <= ui_ff + 1'b1;
            end
         end
         if (cmd.fscan && !stat.fscan_done) begin
            fi_ff <= fi_ff + 1'b1;
            if (cur_len >= size_ff && (!pfound_ff || better)) begin
               pfound_ff <= 1'b1;
               pick_ff   <= fi_idx;
               plen_ff   <= cur_len;
            end
            if (cur_len >= size_ff && !pfound_ff &&
                fit_policy != FIT_BEST && fit_policy != FIT_WORST)
               fi_ff <= fcount_ff;
         end
         if (cmd.fscan && stat.fscan_done)
            status_ff <= pfound_ff ? ST_OK : ST_NO_FIT;
         if (cmd.do_alloc) begin
            rs_ff <= fstart_ff[pick_ff];
            uvalid_ff[slot_ff] <= 1'b1;
            uid_ff[slot_ff]    <= oid_ff;
            ustart_ff[slot_ff] <= fstart_ff[pick_ff];
            ulen_ff[slot_ff]   <= size_ff;
            if (plen_ff > size_ff) begin
               fstart_ff[pick_ff] <= fstart_ff[pick_ff] + size_ff;
               flen_ff[pick_ff]   <= plen_ff - size_ff;
            end else begin
               sh_dir_ff <= 1'b0;
               sh_i_ff   <= FW'(pick_ff);
               sh_end_ff <= fcount_ff;
            end
         end
         if (cmd.ins_pos && !stat.pos_done) fi_ff <= fi_ff + 1'b1;
         if (cmd.do_insert && rl_ff != '0) begin
            if (mp && mn) begin
               flen_ff[fi_prev] <= flen_ff[fi_prev] + rl_ff + flen_ff[fi_idx];
               sh_dir_ff <= 1'b0;
               sh_i_ff   <= fi_ff;
               sh_end_ff <= fcount_ff;
            end else if (mp) begin
               flen_ff[fi_prev] <= flen_ff[fi_prev] + rl_ff;
            end else if (mn) begin
               fstart_ff[fi_idx] <= rs_ff;
               flen_ff[fi_idx]   <= flen_ff[fi_idx] + rl_ff;
            end else if (fcount_ff < FW'(FREE_SLOTS)) begin
               sh_dir_ff <= 1'b1;
               sh_i_ff   <= fcount_ff;
               sh_end_ff <= fi_ff;
               ns_ff <= rs_ff;
               nl_ff <= rl_ff;
            end
         end
         if (cmd.shift) begin
            if (sh_dir_ff) begin
               if (sh_i_ff <= sh_end_ff) begin
                  fstart_ff[sh_idx] <= ns_ff;
                  flen_ff[sh_idx]   <= nl_ff;
                  fcount_ff <= fcount_ff + 1'b1;
               end else begin
                  fstart_ff[sh_idx] <= fstart_ff[sh_idx - 1'b1];
                  flen_ff[sh_idx]   <= flen_ff[sh_idx - 1'b1];
                  sh_i_ff <= sh_i_ff - 1'b1;
               end
            end else begin
               if (sh_i_ff + 1'b1 >= sh_end_ff) begin
                  if (fcount_ff != '0) fcount_ff <= fcount_ff - 1'b1;
               end else begin
                  fstart_ff[sh_idx] <= fstart_ff[sh_idx + 1'b1];
                  flen_ff[sh_idx]   <= flen_ff[sh_idx + 1'b1];
                  sh_i_ff <= sh_i_ff + 1'b1;
               end
            end
         end
      end
   end

   assign out_status = status_ff;
   assign out_start  = (status_ff == ST_OK) ? 16'(rs_ff) : 16'd0;
   assign out_id     = oid_ff;
endmodule

// ----- sv/variable_partition_allocator_top.sv -----
// Top level of the variable partition allocator.
// Sequence: a request beat starts a used-slot scan, then a free-table scan (allocate) or an
//   insert-position search (free), a shift pass if needed, and then the response beat.
// Requests are handled one at a time; the next beat is taken once the response is accepted and the block is idle.
// Reset: synchronous, active high; one free block [0,1024), no regions, id 0.
// A total_size write rebuilds the tables once the block is idle.
module variable_partition_allocator_top #(
   parameter int USED_SLOTS = vpa_pkg::UsedSlotsDefault,
   parameter int FREE_SLOTS = vpa_pkg::FreeSlotsDefault,
   parameter int ADDR_BITS  = vpa_pkg::AddrBitsDefault
) (
   input  logic       clock,
   input  logic       reset,
   vpa_req_if.sink    req,
   vpa_rsp_if.source  rsp,
   vpa_csr_if.sink    csr
);
   import vpa_pkg::*;

   vpa_cmd_type  cmd;
   vpa_stat_type stat;
   logic         idle;
   logic [1:0]   policy_ff;
   logic [15:0]  total_ff;
   logic         init_ff;    // rebuild pending after a total_size beat

   // CSR beats are accepted anytime; rebuild runs before the next request.
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= FIT_FIRST;
         total_ff  <= ResetTotal;
         init_ff   <= 1'b0;
      end else begin
         if (cmd.init) init_ff <= 1'b0;
         if (csr.valid) begin
            unique case (csr.index)
               CSR_FIT_POLICY: policy_ff <= csr.data[1:0];
               CSR_TOTAL_SIZE: begin
                  total_ff <= csr.data;
                  init_ff  <= 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   // Take a request beat only when idle with no rebuild pending.
   assign req.ready = idle;
   assign rsp.valid = cmd.resp;

   vpa_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .start(req.valid), .init_req(init_ff), .rsp_taken(rsp.ready),
      .stat(stat), .cmd(cmd), .idle(idle)
   );

   vpa_dp #(.USED_SLOTS(USED_SLOTS), .FREE_SLOTS(FREE_SLOTS), .ADDR_BITS(ADDR_BITS))
   u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .in_mode(req.mode), .in_size(req.req_size), .in_id(req.owner_id),
      .fit_policy(policy_ff), .total_size(total_ff),
      .out_status(rsp.status), .out_start(rsp.region_start),
      .out_id(rsp.assigned_id)
   );
endmodule

// ----- sv/vpa_checker.sv -----
// Port-level checker for the allocator, bound to the top level.
module vpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_region_start
);
   import vpa_pkg::*;

   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response pending");

   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("response too early");

   a_fail_zero_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_region_start == 16'd0)
      else $error("failed response carries a start");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped while stalled");
endmodule

bind variable_partition_allocator_top vpa_checker u_vpa_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_region_start(rsp.region_start)
);
